FILE: rtl/vmhs_pkg.sv
// Shared types and constants for the VM heap/stack allocator.
package vmhs_pkg;

   localparam int unsigned MEM_BYTES_DEF = 65536;
   localparam int unsigned CELL_BYTES    = 4;
   localparam int unsigned STACK_MARGIN  = 16 * CELL_BYTES;

   localparam int unsigned ADDR_W    = 17;   // heap_top and register width
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned CELLS_W   = 14;
   localparam int unsigned REQ_A_W   = 32;
   localparam int unsigned HDR_W     = 15;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned BLOCK_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_HEAP_LOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_POINTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEMORY_SIZE   = 2'd2;

   // register reset values
   localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 17'd0;
   localparam logic [ADDR_W-1:0] SP_RST        = 17'd65532;
   localparam logic [ADDR_W-1:0] MEM_SIZE_RST  = 17'd65536;

   // controller to datapath
   typedef struct packed {
      logic clr_en;   // clearing pass writes one header entry
      logic accept;   // request taken: capture fields, read header
      logic commit;   // result to output register, state update
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last; // last header entry being cleared
      logic out_free; // output register can take a result
   } sts_type;

endpackage

FILE: rtl/vmhs_ctrl.sv
// Controller state machine: clearing pass, request accept and commit.
module vmhs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vmhs_pkg::sts_type sts,
   output vmhs_pkg::cmd_type cmd
);
   import vmhs_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // header read data is valid here; wait for room at the output
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/vmhs_datapath.sv
// Datapath: registers, heap top, header memory, bound checks, output register.
module vmhs_datapath #(
   parameter int unsigned MEM_BYTES = vmhs_pkg::MEM_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vmhs_pkg::cmd_type                    cmd,
   output vmhs_pkg::sts_type                    sts,
   input  logic [vmhs_pkg::MODE_W-1:0]          req_mode,
   input  logic [vmhs_pkg::CELLS_W-1:0]         req_alloc_cells,
   input  logic signed [vmhs_pkg::REQ_A_W-1:0]  req_address,
   input  logic                                 csr_valid,
   input  logic [vmhs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vmhs_pkg::ADDR_W-1:0]          csr_data,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [vmhs_pkg::STATUS_W-1:0]        rsp_status,
   output logic [vmhs_pkg::BLOCK_W-1:0]         rsp_block_address
);
   import vmhs_pkg::*;

   localparam int unsigned HDR_DEPTH = MEM_BYTES / CELL_BYTES;
   localparam int unsigned IDX_W     = $clog2(HDR_DEPTH);

   // configuration and heap state
   logic [ADDR_W-1:0] base_ff, sp_ff, msize_ff, top_ff, top_in;

   // captured request
   logic [MODE_W-1:0]         mode_ff;
   logic [CELLS_W-1:0]        cells_ff;
   logic signed [REQ_A_W-1:0] addr_ff;

   // header memory
   logic [HDR_W-1:0] hdr_mem [HDR_DEPTH];
   logic [HDR_W-1:0] rd_ff;
   logic             rd_ok_ff;
   logic [IDX_W-1:0] clr_idx_ff;

   // output register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [BLOCK_W-1:0]  block_ff, block_in;

   // header read address from the incoming request
   logic signed [REQ_A_W:0] req_local;
   logic [31:0]             rd_cell;
   logic [IDX_W-1:0]        rd_idx;

   assign req_local = {req_address[REQ_A_W-1], req_address} - 33'sd4;
   assign rd_cell   = 32'(req_local[ADDR_W-1:2]);
   assign rd_idx    = rd_cell[IDX_W-1:0];

   // alloc arithmetic
   logic [15:0]        realmem;
   logic signed [19:0] room;
   logic               heap_low;
   logic [ADDR_W-1:0]  top_alloc;
   logic [31:0]        wr_cell;
   logic               wr_ok;

   assign realmem   = {cells_ff, 2'b00};
   assign room      = $signed({3'b000, sp_ff}) - $signed({3'b000, top_ff})
                      - $signed({4'b0000, realmem});
   assign heap_low  = room < 20'sd64;
   assign top_alloc = top_ff + 17'(CELL_BYTES) + {1'b0, realmem};
   assign wr_cell   = 32'(top_ff[ADDR_W-1:2]);
   assign wr_ok     = wr_cell < 32'(HDR_DEPTH);

   // pop / release / check arithmetic on exact signed values
   logic signed [REQ_A_W:0] a_x, local_x, base_x, sp_x, top_x, msize_x, expect_x;
   logic [HDR_W-1:0]        hdr_val;

   assign a_x      = {addr_ff[REQ_A_W-1], addr_ff};
   assign local_x  = a_x - 33'sd4;
   assign base_x   = $signed({16'd0, base_ff});
   assign sp_x     = $signed({16'd0, sp_ff});
   assign top_x    = $signed({16'd0, top_ff});
   assign msize_x  = $signed({16'd0, msize_ff});
   assign hdr_val  = rd_ok_ff ? rd_ff : '0;
   assign expect_x = top_x - $signed({16'd0, hdr_val, 2'b00}) - 33'sd4;

   logic hdr_we;

   always_comb begin
      status_in = ST_OK;
      block_in  = '0;
      top_in    = top_ff;
      hdr_we    = 1'b0;
      unique case (mode_ff)
         MODE_ALLOC: begin
            if (heap_low) begin
               status_in = ST_HEAP_LOW;
            end else begin
               hdr_we   = wr_ok;
               block_in = top_ff[BLOCK_W-1:0] + 16'(CELL_BYTES);
               top_in   = top_alloc;
            end
         end
         MODE_POP: begin
            if (local_x < base_x || local_x >= sp_x || expect_x != local_x) begin
               status_in = ST_INVALID;
            end else begin
               top_in = local_x[ADDR_W-1:0];
            end
         end
         MODE_RELEASE: begin
            if (a_x < base_x) begin
               status_in = ST_INVALID;
            end else begin
               top_in = local_x[ADDR_W-1:0];
            end
         end
         MODE_CHECK: begin
            if ((a_x >= top_x && a_x < sp_x) || a_x < 0 || a_x >= msize_x) begin
               status_in = ST_INVALID;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff  <= req_mode;
         cells_ff <= req_alloc_cells;
         addr_ff  <= req_address;
         rd_ok_ff <= rd_cell < 32'(HDR_DEPTH);
      end
   end

   // header memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         hdr_mem[clr_idx_ff] <= '0;
      end else if (cmd.commit && hdr_we) begin
         hdr_mem[wr_cell[IDX_W-1:0]] <= {1'b0, cells_ff};
      end
      if (cmd.accept) begin
         rd_ff <= hdr_mem[rd_idx];
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clr_en) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   assign sts.clr_last = clr_idx_ff == IDX_W'(HDR_DEPTH - 1);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // configuration registers and heap top
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= HEAP_BASE_RST;
         sp_ff    <= SP_RST;
         msize_ff <= MEM_SIZE_RST;
         top_ff   <= HEAP_BASE_RST;
      end else begin
         if (cmd.commit) begin
            top_ff <= top_in;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_HEAP_BASE: begin
                  base_ff <= csr_data;
                  top_ff  <= csr_data;
               end
               CSR_STACK_POINTER: begin
                  sp_ff <= csr_data;
               end
               CSR_MEMORY_SIZE: begin
                  msize_ff <= csr_data;
               end
               default: begin
                  base_ff <= base_ff;
               end
            endcase
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         block_ff  <= block_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_block_address = block_ff;

endmodule

FILE: rtl/vm_heap_stack_allocator_top.sv
// Top level of the VM heap/stack allocator: controller plus datapath.
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  mode, alloc_cells, address
//  rsp_      out        rsp_valid / rsp_stall  status, block_address
//  csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// For each request the accept edge issues the header memory read; the commit
// edge, held until the output has room, does the compare and updates heap top
// and the result. After reset all MEM_BYTES/4 header entries (16384 at the
// default) are swept to zero, one a cycle; req_stall is high meanwhile,
// register writes are taken throughout. A held result in the output register
// does not block the next accept; only the commit waits on rsp_stall.
module vm_heap_stack_allocator_top #(
   parameter int unsigned MEM_BYTES = vmhs_pkg::MEM_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // requests
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [vmhs_pkg::MODE_W-1:0]          req_mode,
   input  logic [vmhs_pkg::CELLS_W-1:0]         req_alloc_cells,
   input  logic signed [vmhs_pkg::REQ_A_W-1:0]  req_address,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [vmhs_pkg::STATUS_W-1:0]        rsp_status,
   output logic [vmhs_pkg::BLOCK_W-1:0]         rsp_block_address,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vmhs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vmhs_pkg::ADDR_W-1:0]          csr_data
);
   import vmhs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // registers are plain flops, a write always lands
   assign csr_ready = 1'b1;

   vmhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   vmhs_datapath #(
      .MEM_BYTES (MEM_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req_mode),
      .req_alloc_cells   (req_alloc_cells),
      .req_address       (req_address),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address)
   );

endmodule
